// File: src/assert_macros.svh
// assertion macros shared by the regulator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PVSOR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition that must never hold outside reset
`define PVSOR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `PVSOR_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// File: src/pvsor_pkg.sv
// types and constants of the surplus output regulator
package pvsor_pkg;

  // field widths
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned BUDGET_W  = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // step datapath widths: gain*100 fits 23 bits, times |budget| 39 bits
  localparam int unsigned GAIN100_W = 23;
  localparam int unsigned NUM_W     = GAIN100_W + BUDGET_W;
  // low byte of the product drops out (Q8.8 gain), the rest is divided
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned DVD_W     = NUM_W - FRAC_W;
  localparam int unsigned CNT_W     = $clog2(DVD_W);
  localparam int unsigned SAT_W     = PCT_W + 1;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_RATING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET_MARGIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN    = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0] RATING_RST = 16'd2000;
  localparam logic [CFG_W-1:0] GAIN_RST   = 16'd256;

  typedef struct packed {
    logic signed [BUDGET_W-1:0] power_budget;
    logic [PCT_W-1:0]           target_percent;
    logic                       ctrl_enable;
    logic                       watchdog_kick;
  } in_item_t;

  typedef struct packed {
    logic [PCT_W-1:0] output_percent;
    logic             output_changed;
    logic             watchdog_tripped;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     wdata;
  } cfg_wr_t;

endpackage

// File: src/pvsor_chan_if.sv
// valid/ready channel carrying one payload beat
interface pvsor_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/pv_surplus_output_regulator_unit.sv
// surplus power output regulator: watchdog, ramps and bit-serial budget step
//
//   channel | dir | beat
//   in_i    | in  | power_budget, target_percent, ctrl_enable, watchdog_kick
//   out_o   | out | output_percent, output_changed, watchdog_tripped
//   cfg_i   | in  | register index and write data, always ready
//
// sequence: ramps, deadband and percent mode go from accept to finish; with the
//   budget step: accept, shift-add multiply (one budget bit each, all 16), one
//   dividend load, restoring divide (one quotient bit each, all 31), apply, finish
// reset: asynchronous, clears drive, watchdog counters and loads register defaults
// stalls: a new tick is taken while a finished result waits at out_o; the
//   finish step holds until the output register is free
`include "assert_macros.svh"

module pv_surplus_output_regulator_unit #(
  parameter int unsigned TIMEOUT_TICKS  = 300,
  parameter int unsigned RECOVERY_TICKS = 50
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  pvsor_chan_if.sink          in_i,
  pvsor_chan_if.source        out_o,
  pvsor_chan_if.sink          cfg_i
);

  localparam int unsigned SW = $clog2(TIMEOUT_TICKS + 1);
  localparam int unsigned RW = $clog2(RECOVERY_TICKS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_e;

  state_e state_q;

  // configuration registers
  logic                        mode_q;
  logic [pvsor_pkg::CFG_W-1:0] rating_q;
  logic [pvsor_pkg::CFG_W-1:0] margin_q;
  logic [pvsor_pkg::CFG_W-1:0] gain_q;

  // regulator state
  logic [pvsor_pkg::PCT_W-1:0] drive_q;
  logic [pvsor_pkg::PCT_W-1:0] old_q;
  logic [SW-1:0]               silence_q;
  logic [RW-1:0]               recovery_q;

  // serial step datapath
  logic [pvsor_pkg::NUM_W-1:0]    acc_q;
  logic [pvsor_pkg::NUM_W-1:0]    mcand_q;
  logic [pvsor_pkg::BUDGET_W-1:0] mplier_q;
  logic [pvsor_pkg::DVD_W-1:0]    dvd_q;
  logic [pvsor_pkg::CFG_W-1:0]    rem_q;
  logic [pvsor_pkg::CNT_W-1:0]    cnt_q;
  logic                           neg_q;
  logic                           sticky_q;

  // output register
  logic                 out_valid_q;
  pvsor_pkg::out_item_t out_data_q;

  logic in_accept;
  assign in_accept = in_i.valid && in_i.ready;

  // finished tick moves into the output register
  logic out_load;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  // handshakes
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // tick decode: watchdog service and target saturation
  logic [SW-1:0]                  sil_kick;
  logic [SW-1:0]                  sil_d;
  logic [RW-1:0]                  rec_d;
  logic [pvsor_pkg::PCT_W-1:0]    tgt;
  logic [pvsor_pkg::BUDGET_W-1:0] mag;
  logic [pvsor_pkg::GAIN100_W-1:0] gain100;

  always_comb begin
    sil_kick = in_i.data.watchdog_kick ? '0 : silence_q;
    if (sil_kick < SW'(TIMEOUT_TICKS)) begin
      sil_d = sil_kick + SW'(1);
      rec_d = (recovery_q != '0) ? recovery_q - RW'(1) : recovery_q;
    end else begin
      sil_d = sil_kick;
      rec_d = RW'(RECOVERY_TICKS);
    end
    tgt = (in_i.data.target_percent > pvsor_pkg::PCT_MAX) ? pvsor_pkg::PCT_MAX
                                                          : in_i.data.target_percent;
    mag = in_i.data.power_budget[pvsor_pkg::BUDGET_W-1]
          ? (~in_i.data.power_budget) + pvsor_pkg::BUDGET_W'(1)
          : in_i.data.power_budget;
    // gain * 100 = gain*64 + gain*32 + gain*4
    gain100 = (pvsor_pkg::GAIN100_W'(gain_q) << 6) + (pvsor_pkg::GAIN100_W'(gain_q) << 5)
            + (pvsor_pkg::GAIN100_W'(gain_q) << 2);
  end

  // one restoring divide step
  logic [pvsor_pkg::CFG_W-1:0] divisor;
  logic [pvsor_pkg::CFG_W:0]   rem_shift;
  logic [pvsor_pkg::CFG_W:0]   rem_trial;
  logic                        qbit;

  always_comb begin
    divisor   = (rating_q == '0) ? pvsor_pkg::CFG_W'(1) : rating_q;
    rem_shift = {rem_q, dvd_q[pvsor_pkg::DVD_W-1]};
    rem_trial = rem_shift - {1'b0, divisor};
    qbit      = !rem_trial[pvsor_pkg::CFG_W];
  end

  // apply the finished step with truncation toward minus infinity and clamp
  logic [pvsor_pkg::SAT_W-1:0] qsat;
  logic [pvsor_pkg::SAT_W-1:0] qneg;
  logic [pvsor_pkg::SAT_W-1:0] sum;
  logic [pvsor_pkg::PCT_W-1:0] next_drive;

  always_comb begin
    qsat = (|dvd_q[pvsor_pkg::DVD_W-1:pvsor_pkg::PCT_W])
           ? {1'b0, {pvsor_pkg::PCT_W{1'b1}}}
           : {1'b0, dvd_q[pvsor_pkg::PCT_W-1:0]};
    qneg = qsat + pvsor_pkg::SAT_W'(sticky_q || (rem_q != '0));
    sum  = {1'b0, drive_q} + qsat;
    if (!neg_q) begin
      next_drive = (sum > {1'b0, pvsor_pkg::PCT_MAX}) ? pvsor_pkg::PCT_MAX
                                                      : sum[pvsor_pkg::PCT_W-1:0];
    end else if ({1'b0, drive_q} >= qneg) begin
      next_drive = drive_q - qneg[pvsor_pkg::PCT_W-1:0];
    end else begin
      next_drive = '0;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b1;
      rating_q <= pvsor_pkg::RATING_RST;
      margin_q <= '0;
      gain_q   <= pvsor_pkg::GAIN_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.index)
        pvsor_pkg::REG_BUDGET_MODE:   mode_q   <= cfg_i.data.wdata[0];
        pvsor_pkg::REG_POWER_RATING:  rating_q <= cfg_i.data.wdata;
        pvsor_pkg::REG_BUDGET_MARGIN: margin_q <= cfg_i.data.wdata;
        pvsor_pkg::REG_ERROR_GAIN:    gain_q   <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // sequencer, regulator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      drive_q     <= '0;
      old_q       <= '0;
      silence_q   <= '0;
      recovery_q  <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      acc_q       <= '0;
      mcand_q     <= '0;
      mplier_q    <= '0;
      dvd_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            old_q      <= drive_q;
            silence_q  <= sil_d;
            // a disabled controller in budget mode clears the recovery count
            recovery_q <= (mode_q && !in_i.data.ctrl_enable) ? '0 : rec_d;
            if (!mode_q) begin
              // percent mode: one step toward the target
              state_q <= ST_FINISH;
              if (tgt > drive_q) begin
                drive_q <= drive_q + pvsor_pkg::PCT_W'(1);
              end else if (tgt < drive_q) begin
                drive_q <= drive_q - pvsor_pkg::PCT_W'(1);
              end
            end else if ((rec_d != '0) || !in_i.data.ctrl_enable) begin
              // disabled or tripped: ramp down
              state_q <= ST_FINISH;
              if (drive_q != '0) begin
                drive_q <= drive_q - pvsor_pkg::PCT_W'(1);
              end
            end else if (mag > margin_q) begin
              // outside deadband: start the serial step
              acc_q    <= '0;
              mcand_q  <= pvsor_pkg::NUM_W'(gain100);
              mplier_q <= mag;
              neg_q    <= in_i.data.power_budget[pvsor_pkg::BUDGET_W-1];
              cnt_q    <= '0;
              state_q  <= ST_MUL;
            end else begin
              // inside deadband: drive holds
              state_q <= ST_FINISH;
            end
          end
        end
        ST_MUL: begin
          if (mplier_q[0]) begin
            acc_q <= acc_q + mcand_q;
          end
          mcand_q  <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q    <= cnt_q + pvsor_pkg::CNT_W'(1);
          if (cnt_q == pvsor_pkg::CNT_W'(pvsor_pkg::BUDGET_W - 1)) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // load the dividend above the fraction byte
          dvd_q    <= acc_q[pvsor_pkg::NUM_W-1:pvsor_pkg::FRAC_W];
          sticky_q <= |acc_q[pvsor_pkg::FRAC_W-1:0];
          rem_q    <= '0;
          cnt_q    <= '0;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= qbit ? rem_trial[pvsor_pkg::CFG_W-1:0] : rem_shift[pvsor_pkg::CFG_W-1:0];
          dvd_q <= {dvd_q[pvsor_pkg::DVD_W-2:0], qbit};
          cnt_q <= cnt_q + pvsor_pkg::CNT_W'(1);
          if (cnt_q == pvsor_pkg::CNT_W'(pvsor_pkg::DVD_W - 1)) begin
            state_q <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          drive_q <= next_drive;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            out_data_q.output_percent   <= drive_q;
            out_data_q.output_changed   <= (drive_q != old_q);
            out_data_q.watchdog_tripped <= (recovery_q != '0);
            state_q                     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // checks
  `PVSOR_ASSERT_NEVER(a_drive_range, clk_i, rst_ni, drive_q > pvsor_pkg::PCT_MAX,
                      "drive above full scale")
  `PVSOR_ASSERT(a_drive_source, clk_i, rst_ni,
                !$stable(drive_q) |-> ($past(state_q) == ST_APPLY || $past(in_accept)),
                "drive moved outside a tick")
  `PVSOR_ASSERT(a_finish_loads, clk_i, rst_ni,
                (state_q == ST_FINISH && (!out_valid_q || out_o.ready))
                |=> (out_valid_q && state_q == ST_IDLE),
                "finished tick not presented")

endmodule

// File: tb/pv_surplus_output_regulator_unit_test.sv
// testbench of the surplus output regulator: ticks driven, results checked against a local model
`timescale 1ns / 100ps

module pv_surplus_output_regulator_unit_test;

  localparam int unsigned TIMEOUT_TICKS  = 300;
  localparam int unsigned RECOVERY_TICKS = 50;
  // receiver hold-off start and the stretch without idling, counted in accepted ticks; hold-off length in clocks
  localparam int unsigned HOLD_AT        = 150;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned CALM_FROM      = 400;
  localparam int unsigned CALM_TO        = 520;
  localparam int unsigned QUIET_LIMIT    = 4000;
  localparam int unsigned IDLE_PCT       = 30;

  logic clk_i = 1'b0;
  logic rst_ni;

  pvsor_chan_if #(.T(pvsor_pkg::in_item_t))  in_ch ();
  pvsor_chan_if #(.T(pvsor_pkg::out_item_t)) out_ch ();
  pvsor_chan_if #(.T(pvsor_pkg::cfg_wr_t))   cfg_ch ();

  pv_surplus_output_regulator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // clock
  always #6 clk_i = ~clk_i;

  // ticks waiting to be driven and results waiting to arrive
  pvsor_pkg::in_item_t  tick_queue[$];
  pvsor_pkg::out_item_t drive_expect_q[$];

  // model state and register copies
  logic [pvsor_pkg::PCT_W-1:0] drive_pct;
  logic [8:0]                  silence_cnt;
  logic [5:0]                  recovery_cnt;
  logic                        budget_mode_q;
  logic [pvsor_pkg::CFG_W-1:0] rating_q;
  logic [pvsor_pkg::CFG_W-1:0] margin_q;
  logic [pvsor_pkg::CFG_W-1:0] gain_q;

  int unsigned          beats_in;
  int unsigned          mismatches;
  int unsigned          quiet_cycles;
  int unsigned          hold_left;
  logic                 hold_done;
  logic                 rdy;
  pvsor_pkg::out_item_t want;

  // one control tick: watchdog service, then drive update
  function automatic pvsor_pkg::out_item_t regulate_tick(pvsor_pkg::in_item_t t);
    logic [pvsor_pkg::PCT_W-1:0] tgt;
    logic [pvsor_pkg::PCT_W-1:0] prev;
    longint                      budget;
    longint                      nxt;
    longint unsigned             den;
    longint unsigned             mag;
    longint unsigned             num;
    longint unsigned             quo;
    pvsor_pkg::out_item_t        r;
    budget = longint'($signed(t.power_budget));
    tgt    = (t.target_percent > pvsor_pkg::PCT_MAX) ? pvsor_pkg::PCT_MAX : t.target_percent;
    prev   = drive_pct;

    if (t.watchdog_kick) silence_cnt = '0;
    if (silence_cnt < TIMEOUT_TICKS) begin
      silence_cnt = silence_cnt + 9'd1;
      if (recovery_cnt != '0) recovery_cnt = recovery_cnt - 6'd1;
    end else begin
      recovery_cnt = 6'(RECOVERY_TICKS);
    end

    if (!budget_mode_q) begin
      // percent mode: one step toward the target
      if (tgt > drive_pct) drive_pct = drive_pct + pvsor_pkg::PCT_W'(1);
      else if (tgt < drive_pct) drive_pct = drive_pct - pvsor_pkg::PCT_W'(1);
    end else if (recovery_cnt != '0 || !t.ctrl_enable) begin
      if (!t.ctrl_enable) recovery_cnt = '0;
      if (drive_pct != '0) drive_pct = drive_pct - pvsor_pkg::PCT_W'(1);
    end else begin
      // budget step, floored, outside the deadband only
      nxt = longint'(drive_pct);
      if (budget > longint'(margin_q) || budget < -longint'(margin_q)) begin
        den = 64'((rating_q == '0) ? 16'd1 : rating_q) * 64'd256;
        mag = (budget < 0) ? 64'(-budget) : 64'(budget);
        num = 64'(gain_q) * 64'd100 * mag;
        quo = num / den;
        if (budget < 0) begin
          if (num % den != 0) quo = quo + 1;
          nxt = nxt - longint'(quo);
        end else begin
          nxt = nxt + longint'(quo);
        end
      end
      if (nxt > 100) nxt = 100;
      else if (nxt < 0) nxt = 0;
      drive_pct = nxt[pvsor_pkg::PCT_W-1:0];
    end

    r.output_percent   = drive_pct;
    r.output_changed   = (drive_pct != prev);
    r.watchdog_tripped = (recovery_cnt != '0);
    return r;
  endfunction

  // random tick: budget near extremes, around a useful step size, at the deadband edge or fully random
  function automatic pvsor_pkg::in_item_t random_tick(int unsigned scale,
                                                      logic [pvsor_pkg::CFG_W-1:0] margin,
                                                      int unsigned kick_pct,
                                                      int unsigned en_pct);
    pvsor_pkg::in_item_t t;
    int unsigned         pick;
    longint              v;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: v = 32767;
        1: v = -32768;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
    end else if (pick < 55) begin
      v = longint'($urandom_range(2 * scale)) - longint'(scale);
    end else if (pick < 75) begin
      v = longint'(margin) + longint'($urandom_range(2)) - 1;
      if ($urandom_range(1) != 0) v = -v;
    end else begin
      v = longint'($signed(16'($urandom())));
    end
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    t.power_budget   = v[pvsor_pkg::BUDGET_W-1:0];
    t.target_percent = pvsor_pkg::PCT_W'($urandom_range(127));
    t.ctrl_enable    = ($urandom_range(99) < en_pct);
    t.watchdog_kick  = ($urandom_range(99) < kick_pct);
    return t;
  endfunction

  task automatic push_tick(input logic signed [pvsor_pkg::BUDGET_W-1:0] budget,
                           input logic [pvsor_pkg::PCT_W-1:0] target, input logic en,
                           input logic kick);
    pvsor_pkg::in_item_t t;
    t.power_budget   = budget;
    t.target_percent = target;
    t.ctrl_enable    = en;
    t.watchdog_kick  = kick;
    tick_queue.push_back(t);
  endtask

  // register write beat on the config channel
  task automatic write_reg(input logic [pvsor_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pvsor_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.wdata <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // sender pause until every expected result is back
  task automatic drain();
    do @(negedge clk_i);
    while (tick_queue.size() != 0 || in_ch.valid || drive_expect_q.size() != 0);
  endtask

  task automatic run_phase(input logic mode, input logic [pvsor_pkg::CFG_W-1:0] rating,
                           input logic [pvsor_pkg::CFG_W-1:0] margin,
                           input logic [pvsor_pkg::CFG_W-1:0] gain,
                           input int unsigned n_lead, input int unsigned n_starve,
                           input int unsigned n_tail);
    longint      span;
    int unsigned scale;
    write_reg(pvsor_pkg::REG_BUDGET_MODE, {15'd0, mode});
    write_reg(pvsor_pkg::REG_POWER_RATING, rating);
    write_reg(pvsor_pkg::REG_BUDGET_MARGIN, margin);
    write_reg(pvsor_pkg::REG_ERROR_GAIN, gain);
    // budget that gives a step of about five percent
    span = (longint'((rating == '0) ? 16'd1 : rating) * 1280) /
           (100 * longint'((gain == '0) ? 16'd1 : gain)) + 1;
    if (span > 32767) span = 32767;
    scale = 32'(span);
    @(negedge clk_i);
    repeat (n_lead) tick_queue.push_back(random_tick(scale, margin, 90, 85));
    // no kicks: the watchdog runs out and the recovery counter loads
    repeat (n_starve) tick_queue.push_back(random_tick(scale, margin, 0, 95));
    repeat (n_tail) tick_queue.push_back(random_tick(scale, margin, 95, 95));
    drain();
  endtask

  // driver: input beats, model update on every accepted tick and register write
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid   <= 1'b0;
      in_ch.data    <= '0;
      beats_in      <= 0;
      drive_pct     = '0;
      silence_cnt   = '0;
      recovery_cnt  = '0;
      budget_mode_q = 1'b1;
      rating_q      = pvsor_pkg::RATING_RST;
      margin_q      = '0;
      gain_q        = pvsor_pkg::GAIN_RST;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.data.index)
          pvsor_pkg::REG_BUDGET_MODE:   budget_mode_q = cfg_ch.data.wdata[0];
          pvsor_pkg::REG_POWER_RATING:  rating_q      = cfg_ch.data.wdata;
          pvsor_pkg::REG_BUDGET_MARGIN: margin_q      = cfg_ch.data.wdata;
          pvsor_pkg::REG_ERROR_GAIN:    gain_q        = cfg_ch.data.wdata;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        drive_expect_q.push_back(regulate_tick(in_ch.data));
        beats_in <= beats_in + 1;
      end
      // hold the beat while it is refused, else offer the next one or idle
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (tick_queue.size() != 0 &&
            ((beats_in >= CALM_FROM && beats_in < CALM_TO) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= tick_queue.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: result beats compared with the oldest expectation
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    = 0;
      hold_done    = 1'b0;
      mismatches   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_expect_q.size() == 0) begin
          $error("result beat with no tick outstanding");
          mismatches++;
        end else begin
          want = drive_expect_q.pop_front();
          if (out_ch.data.output_percent !== want.output_percent) begin
            $error("output_percent expected %0d got %0d",
                   want.output_percent, out_ch.data.output_percent);
            mismatches++;
          end
          if (out_ch.data.output_changed !== want.output_changed) begin
            $error("output_changed expected %0b got %0b",
                   want.output_changed, out_ch.data.output_changed);
            mismatches++;
          end
          if (out_ch.data.watchdog_tripped !== want.watchdog_tripped) begin
            $error("watchdog_tripped expected %0b got %0b",
                   want.watchdog_tripped, out_ch.data.watchdog_tripped);
            mismatches++;
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!hold_done && beats_in == HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = (beats_in >= CALM_FROM && beats_in < CALM_TO) ||
              ($urandom_range(99) >= IDLE_PCT);
      end
      out_ch.ready <= rdy;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus sequence
  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // budget mode with reset registers: clamps, floor of negative steps, deadband, disable
    @(negedge clk_i);
    push_tick(16'sd32767, 7'd0, 1'b1, 1'b1);
    push_tick(16'sd0, 7'd0, 1'b1, 1'b1);
    push_tick(-16'sd32768, 7'd0, 1'b1, 1'b1);
    push_tick(16'sd40, 7'd0, 1'b1, 1'b1);
    push_tick(16'sd19, 7'd0, 1'b1, 1'b1);
    push_tick(-16'sd1, 7'd0, 1'b1, 1'b1);
    push_tick(-16'sd20, 7'd0, 1'b1, 1'b1);
    push_tick(16'sd2000, 7'd0, 1'b1, 1'b0);
    push_tick(16'sd0, 7'd100, 1'b0, 1'b1);
    push_tick(16'sd0, 7'd127, 1'b0, 1'b0);
    push_tick(16'sd32767, 7'd127, 1'b1, 1'b1);
    push_tick(16'sd1, 7'd0, 1'b1, 1'b1);
    drain();

    // percent mode: saturated target, ramp down, enable and budget ignored
    write_reg(pvsor_pkg::REG_BUDGET_MODE, 16'd0);
    @(negedge clk_i);
    push_tick(16'sd0, 7'd127, 1'b1, 1'b1);
    push_tick(16'sd0, 7'd0, 1'b1, 1'b1);
    push_tick(16'sd0, 7'd0, 1'b1, 1'b0);
    push_tick(16'sd0, 7'd100, 1'b0, 1'b1);
    push_tick(16'sd0, 7'd99, 1'b1, 1'b1);
    push_tick(-16'sd32768, 7'd50, 1'b1, 1'b1);
    push_tick(16'sd32767, 7'd101, 1'b0, 1'b0);
    drain();

    // random phases over several register settings
    run_phase(1'b1, 16'd100, 16'd0, 16'hffff, 70, 0, 0);
    run_phase(1'b0, 16'd2000, 16'd0, 16'd256, 70, 0, 0);
    run_phase(1'b1, 16'd0, 16'd5, 16'd1, 70, 0, 0);
    run_phase(1'b1, 16'hffff, 16'hffff, 16'd0, 60, 0, 0);
    run_phase(1'b1, 16'd3000, 16'd50, 16'd512, 30, 305, 30);
    run_phase(1'b1, 16'($urandom_range(65535, 100)), 16'($urandom_range(200)),
              16'($urandom_range(65535, 1)), 80, 0, 0);
    run_phase(1'b1, 16'd1, 16'd0, 16'd256, 40, 0, 0);

    // let any stray result show up
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
